FILE: design/tdpt_pkg.sv
package tdpt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // Field widths of the request and response words.
   localparam int VALUE_W = 31;
   localparam int SUM_W   = 64;
   localparam int ENTRY_W = 13;

   // Request operation codes.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_TEST   = 1'b1;

endpackage

FILE: design/tdpt_if.sv
// Request channel: one word per candidate value.
interface tdpt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [tdpt_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one word per request.
interface tdpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found_prime;
   logic                          appended;
   logic                          table_full;
   logic [tdpt_pkg::SUM_W-1:0]    prime_sum;
   logic [tdpt_pkg::ENTRY_W-1:0]  entry_count;

   modport source (output valid, output found_prime, output appended, output table_full,
                   output prime_sum, output entry_count, input ready);
   modport sink   (input valid, input found_prime, input appended, input table_full,
                   input prime_sum, input entry_count, output ready);
endinterface

FILE: design/trial_division_prime_table.sv
// Sequence: an append word goes from acceptance through the commit and reply states and loads
// the response register once it is free. A test word walks the table: each entry is fetched,
// squared and checked against the square bound, then trial-divided (one quotient bit per cycle).
// Throughput: one word is in flight; the next is accepted the cycle after the response loads.
// Reset (synchronous) clears the entry count, the running sum and all control;
// the table memory itself is not cleared and needs no clearing pass.
module trial_division_prime_table (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_port,
   tdpt_rsp_if.source rsp_port
);

   localparam int BIT_CNT_W = $clog2(tdpt_pkg::VALUE_W);
   localparam int REM_W     = tdpt_pkg::VALUE_W + 1;
   localparam int SQ_W      = 2 * tdpt_pkg::VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQUARE,
      ST_BOUND,
      ST_DIVIDE,
      ST_REMAIN,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   // Sequencer and working registers.
   state_type                      state_ff,       state_in;
   logic                           op_ff,          op_in;
   logic [tdpt_pkg::VALUE_W-1:0]   value_ff,       value_in;
   logic [tdpt_pkg::COUNT_W-1:0]   idx_ff,         idx_in;
   logic [tdpt_pkg::VALUE_W-1:0]   p_ff,           p_in;
   logic [SQ_W-1:0]                square_ff,      square_in;
   logic [REM_W-1:0]               rem_ff,         rem_in;
   logic [tdpt_pkg::VALUE_W-1:0]   dividend_ff,    dividend_in;
   logic [BIT_CNT_W-1:0]           bit_cnt_ff,     bit_cnt_in;
   logic                           prime_ff,       prime_in;
   logic                           appended_ff,    appended_in;
   logic                           full_ff,        full_in;
   logic [tdpt_pkg::COUNT_W-1:0]   count_ff,       count_in;
   logic [tdpt_pkg::SUM_W-1:0]     sum_ff,         sum_in;

   // Registered response word.
   logic                           rsp_valid_ff,   rsp_valid_in;
   logic                           rsp_prime_ff,   rsp_prime_in;
   logic                           rsp_app_ff,     rsp_app_in;
   logic                           rsp_full_ff,    rsp_full_in;
   logic [tdpt_pkg::SUM_W-1:0]     rsp_sum_ff,     rsp_sum_in;
   logic [tdpt_pkg::ENTRY_W-1:0]   rsp_count_ff,   rsp_count_in;

   // Table memory with a registered read port.
   logic [tdpt_pkg::VALUE_W-1:0]   prime_store [tdpt_pkg::TABLE_DEPTH];
   logic [tdpt_pkg::VALUE_W-1:0]   rd_data_ff;
   logic                           mem_we;

   // Divider step signals.
   logic [REM_W-1:0]               rem_shift;
   logic [REM_W-1:0]               p_wide;
   logic                           want_store;

   assign req_port.ready       = (state_ff == ST_IDLE);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.found_prime = rsp_prime_ff;
   assign rsp_port.appended    = rsp_app_ff;
   assign rsp_port.table_full  = rsp_full_ff;
   assign rsp_port.prime_sum   = rsp_sum_ff;
   assign rsp_port.entry_count = rsp_count_ff;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign rem_shift  = {rem_ff[tdpt_pkg::VALUE_W-1:0], dividend_ff[tdpt_pkg::VALUE_W-1]};
   assign p_wide     = {1'b0, p_ff};
   assign want_store = (op_ff == tdpt_pkg::OP_APPEND) || prime_ff;
   assign mem_we     = (state_ff == ST_COMMIT) && want_store &&
                       (count_ff < tdpt_pkg::COUNT_W'(tdpt_pkg::TABLE_DEPTH));

   // Table write at the fill count, read at the walk index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         prime_store[count_ff[tdpt_pkg::ADDR_W-1:0]] <= value_ff;
      end
      rd_data_ff <= prime_store[idx_ff[tdpt_pkg::ADDR_W-1:0]];
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      square_in    = square_ff;
      rem_in       = rem_ff;
      dividend_in  = dividend_ff;
      bit_cnt_in   = bit_cnt_ff;
      prime_in     = prime_ff;
      appended_in  = appended_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_app_in   = rsp_app_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;

      // A waiting response word leaves when the sink takes it.
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               op_in       = req_port.op;
               value_in    = req_port.value;
               idx_in      = '0;
               prime_in    = 1'b0;
               appended_in = 1'b0;
               full_in     = 1'b0;
               if (req_port.op == tdpt_pkg::OP_TEST) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_FETCH: begin
            // Running off the end of the table means no divisor was found.
            if (idx_ff == count_ff) begin
               prime_in = 1'b1;
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            p_in      = rd_data_ff;
            square_in = SQ_W'(rd_data_ff) * SQ_W'(rd_data_ff);
            state_in  = ST_BOUND;
         end
         ST_BOUND: begin
            // Past the square root ends the walk; a stored zero is skipped.
            if (square_ff > {{tdpt_pkg::VALUE_W{1'b0}}, value_ff}) begin
               prime_in = 1'b1;
               state_in = ST_COMMIT;
            end else if (p_ff == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               rem_in      = '0;
               dividend_in = value_ff;
               bit_cnt_in  = '0;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_shift >= p_wide) begin
               rem_in = rem_shift - p_wide;
            end else begin
               rem_in = rem_shift;
            end
            dividend_in = dividend_ff << 1;
            bit_cnt_in  = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(tdpt_pkg::VALUE_W - 1)) begin
               state_in = ST_REMAIN;
            end
         end
         ST_REMAIN: begin
            if (rem_ff == '0) begin
               prime_in = 1'b0;
               state_in = ST_COMMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_COMMIT: begin
            if (want_store) begin
               if (count_ff < tdpt_pkg::COUNT_W'(tdpt_pkg::TABLE_DEPTH)) begin
                  count_in    = count_ff + 1'b1;
                  sum_in      = sum_ff + tdpt_pkg::SUM_W'(value_ff);
                  appended_in = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // Load the response register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               rsp_app_in   = appended_ff;
               rsp_full_in  = full_ff;
               rsp_sum_in   = sum_ff;
               rsp_count_in = tdpt_pkg::ENTRY_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      p_ff         <= p_in;
      square_ff    <= square_in;
      rem_ff       <= rem_in;
      dividend_ff  <= dividend_in;
      bit_cnt_ff   <= bit_cnt_in;
      prime_ff     <= prime_in;
      appended_ff  <= appended_in;
      full_ff      <= full_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_app_ff   <= rsp_app_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   // The fill count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= tdpt_pkg::COUNT_W'(tdpt_pkg::TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // The partial remainder stays below the divisor throughout a division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < p_wide))
      else $error("divider remainder out of range");

   // Only one word is in flight: acceptance drops ready on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("second request accepted while one is in flight");

endmodule
